// ===== src/pixel_to_ansi256_nearest_core_defines.svh =====
// ----------------------------------------------------------------------------
// pixel to ansi256 nearest core - assertion macros
// shared concurrent assertion helpers for the rtl files
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_ANSI256_NEAREST_CORE_DEFINES_SVH
`define PIXEL_TO_ANSI256_NEAREST_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define P2A_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define P2A_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/p2a_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2a_pkg
// types, constants and the fixed xterm palette for the nearest-color core
// ----------------------------------------------------------------------------
package p2a_pkg;

  // arithmetic constants
  localparam logic [8:0] HUE_BASE_GREEN = 9'd120;
  localparam logic [8:0] HUE_BASE_BLUE  = 9'd240;
  localparam logic [8:0] HUE_FULL       = 9'd360;
  localparam logic [7:0] HUE_SCALE      = 8'd60;
  localparam logic [7:0] PCT_SCALE      = 8'd100;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;
  localparam logic [8:0] SUM_FULL       = 9'd510;

  // shared divider geometry
  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 9;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // distance widths
  localparam int SQ_W   = 17;
  localparam int DIST_W = 18;

  // register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [0:0] REG_MATCH_SPACE = 1'b0;
  localparam logic       MATCH_SPACE_RST = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef struct packed {
    logic [8:0] h;
    logic [6:0] s;
    logic [6:0] l;
  } hsl_t;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_ch_e;

  typedef enum logic [3:0] {
    HS_IDLE,
    HS_MULT,
    HS_RANGE,
    HS_LIGHT,
    HS_HUE_GO,
    HS_HUE_WAIT,
    HS_SAT_GO,
    HS_SAT_WAIT,
    HS_DONE
  } hsl_state_e;

  typedef enum logic [2:0] {
    ST_FILL_GO,
    ST_FILL_WAIT,
    ST_IDLE,
    ST_CONV,
    ST_SEARCH,
    ST_HOLD
  } top_state_e;

  typedef logic [23:0] rgb_word_t;
  typedef rgb_word_t rgb_table_t [256];

  // floor(x/255), exact while the quotient stays at or below 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic rgb_word_t basic_color(input int k);
    rgb_word_t c;
    case (k)
      0:       c = 24'h000000;
      1:       c = 24'h800000;
      2:       c = 24'h008000;
      3:       c = 24'h808000;
      4:       c = 24'h000080;
      5:       c = 24'h800080;
      6:       c = 24'h008080;
      7:       c = 24'hC0C0C0;
      8:       c = 24'h808080;
      9:       c = 24'hFF0000;
      10:      c = 24'h00FF00;
      11:      c = 24'hFFFF00;
      12:      c = 24'h0000FF;
      13:      c = 24'hFF00FF;
      14:      c = 24'h00FFFF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cube_level(input int k);
    logic [7:0] v;
    case (k)
      0:       v = 8'd0;
      1:       v = 8'd95;
      2:       v = 8'd135;
      3:       v = 8'd175;
      4:       v = 8'd215;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  function automatic rgb_table_t build_rgb_table();
    rgb_table_t t;
    logic [7:0] v;
    for (int i = 0; i < 16; i++) begin
      t[i] = basic_color(i);
    end
    for (int i = 0; i < 216; i++) begin
      t[16 + i] = {cube_level(i / 36), cube_level((i / 6) % 6), cube_level(i % 6)};
    end
    for (int i = 0; i < 24; i++) begin
      v = 8'(8 + 10 * i);
      t[232 + i] = {v, v, v};
    end
    return t;
  endfunction

  localparam rgb_table_t PAL_RGB = build_rgb_table();

endpackage

// ===== src/p2a_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2a_if
// valid/ready channels for pixel beats and nearest-color result beats
// ----------------------------------------------------------------------------
interface p2a_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

interface p2a_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;
  logic [8:0] hue;
  logic [6:0] saturation;
  logic [6:0] lightness;

  modport source (output valid, output palette_index, output hue, output saturation,
                  output lightness, input ready);
  modport sink   (input valid, input palette_index, input hue, input saturation,
                  input lightness, output ready);
endinterface

// ===== src/p2a_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2a_div
// restoring divider, one quotient bit per cycle, shared by hue and saturation
// ----------------------------------------------------------------------------
module p2a_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [p2a_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [p2a_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                           done_o,
  output logic [p2a_pkg::DIV_NUM_W-1:0]  quot_o,
  output logic                           rem_nz_o
);

  localparam int NW = p2a_pkg::DIV_NUM_W;
  localparam int DW = p2a_pkg::DIV_DEN_W;
  localparam int CW = p2a_pkg::DIV_CNT_W;

  logic          active_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quot_q, quot_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial  = {rem_q, quot_q[NW-1]};
    ge     = (trial >= {1'b0, den_q});
    rem_d  = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
    quot_d = {quot_q[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
      end else if (active_q && (cnt_q == CW'(NW - 1))) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
      cnt_q  <= '0;
    end else if (active_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quot_q;
  assign rem_nz_o = |rem_q;

endmodule

// ===== src/p2a_hsl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2a_hsl
// alpha premultiply and integer hsl conversion under a small sequencer
// ----------------------------------------------------------------------------
module p2a_hsl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  p2a_pkg::pix_t pix_i,
  input  logic [7:0]    alpha_i,
  output logic          done_o,
  output p2a_pkg::pix_t pre_o,
  output p2a_pkg::hsl_t hsl_o
);

  p2a_pkg::hsl_state_e state_q, state_d;

  p2a_pkg::pix_t    src_q;
  p2a_pkg::pix_t    pre_q;
  logic [7:0]       alpha_q;
  logic [1:0]       ch_q;
  p2a_pkg::max_ch_e maxc_q;
  logic [7:0]       dlt_q;
  logic [8:0]       sum_q;
  logic [7:0]       sden_q;
  logic [7:0]       adiff_q;
  logic             neg_q;
  p2a_pkg::hsl_t    hsl_q;

  // divider hookup
  logic                          div_start;
  logic [p2a_pkg::DIV_NUM_W-1:0] div_num;
  logic [p2a_pkg::DIV_DEN_W-1:0] div_den;
  logic                          div_done;
  logic [p2a_pkg::DIV_NUM_W-1:0] div_quot;
  logic                          div_rem_nz;

  p2a_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .done_o   (div_done),
    .quot_o   (div_quot),
    .rem_nz_o (div_rem_nz)
  );

  // premultiply, one channel a cycle through a single 8x8 product
  logic [7:0]  mul_c;
  logic [15:0] mul_p;
  logic [7:0]  mul_q8;

  always_comb begin
    case (ch_q)
      2'd0:    mul_c = src_q.r;
      2'd1:    mul_c = src_q.g;
      default: mul_c = src_q.b;
    endcase
    mul_p  = 16'(alpha_q) * 16'(mul_c);
    mul_q8 = p2a_pkg::div255(mul_p);
  end

  // range analysis on the premultiplied color
  logic             red_max, green_max;
  logic [7:0]       mx, mn, pa, pb;
  p2a_pkg::max_ch_e maxc;

  always_comb begin
    red_max   = (pre_q.r >= pre_q.g) && (pre_q.r >= pre_q.b);
    green_max = !red_max && (pre_q.g >= pre_q.b);
    if (red_max) begin
      maxc = p2a_pkg::MAX_RED;
      mx   = pre_q.r;
      pa   = pre_q.g;
      pb   = pre_q.b;
    end else if (green_max) begin
      maxc = p2a_pkg::MAX_GREEN;
      mx   = pre_q.g;
      pa   = pre_q.b;
      pb   = pre_q.r;
    end else begin
      maxc = p2a_pkg::MAX_BLUE;
      mx   = pre_q.b;
      pa   = pre_q.r;
      pb   = pre_q.g;
    end
    mn = pre_q.r;
    if (pre_q.g < mn) mn = pre_q.g;
    if (pre_q.b < mn) mn = pre_q.b;
  end

  // lightness
  logic [15:0] lit_p;
  logic [7:0]  lit_q8;

  always_comb begin
    lit_p  = 16'(sum_q) * 16'(p2a_pkg::PCT_SCALE);
    lit_q8 = p2a_pkg::div255(lit_p);
  end

  // hue from the divider result, floor for negative differences
  logic [6:0] hue_mag;
  logic [8:0] hue_base, hue_top, hue_val;

  always_comb begin
    hue_mag = 7'(div_quot[6:0]) + 7'(div_rem_nz);
    case (maxc_q)
      p2a_pkg::MAX_GREEN: hue_base = p2a_pkg::HUE_BASE_GREEN;
      p2a_pkg::MAX_BLUE:  hue_base = p2a_pkg::HUE_BASE_BLUE;
      default:            hue_base = '0;
    endcase
    hue_top = ((maxc_q == p2a_pkg::MAX_RED) && neg_q) ? p2a_pkg::HUE_FULL : hue_base;
    hue_val = neg_q ? (hue_top - 9'(hue_mag)) : (hue_top + 9'(div_quot[6:0]));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      p2a_pkg::HS_IDLE:     if (start_i) state_d = p2a_pkg::HS_MULT;
      p2a_pkg::HS_MULT:     if (ch_q == 2'd2) state_d = p2a_pkg::HS_RANGE;
      p2a_pkg::HS_RANGE:    state_d = p2a_pkg::HS_LIGHT;
      p2a_pkg::HS_LIGHT:    state_d = (dlt_q == '0) ? p2a_pkg::HS_DONE : p2a_pkg::HS_HUE_GO;
      p2a_pkg::HS_HUE_GO:   state_d = p2a_pkg::HS_HUE_WAIT;
      p2a_pkg::HS_HUE_WAIT: if (div_done) state_d = p2a_pkg::HS_SAT_GO;
      p2a_pkg::HS_SAT_GO:   state_d = p2a_pkg::HS_SAT_WAIT;
      p2a_pkg::HS_SAT_WAIT: if (div_done) state_d = p2a_pkg::HS_DONE;
      p2a_pkg::HS_DONE:     state_d = p2a_pkg::HS_IDLE;
      default:              state_d = p2a_pkg::HS_IDLE;
    endcase
  end

  // outputs toward the divider and the caller
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    done_o    = 1'b0;
    unique case (state_q)
      p2a_pkg::HS_HUE_GO: begin
        div_start = 1'b1;
        div_num   = 16'(p2a_pkg::HUE_SCALE) * 16'(adiff_q);
        div_den   = {1'b0, dlt_q};
      end
      p2a_pkg::HS_SAT_GO: begin
        div_start = 1'b1;
        div_num   = 16'(p2a_pkg::PCT_SCALE) * 16'(dlt_q);
        div_den   = {1'b0, sden_q};
      end
      p2a_pkg::HS_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= p2a_pkg::HS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      p2a_pkg::HS_IDLE: begin
        if (start_i) begin
          src_q   <= pix_i;
          alpha_q <= alpha_i;
          ch_q    <= 2'd0;
        end
      end
      p2a_pkg::HS_MULT: begin
        case (ch_q)
          2'd0:    pre_q.r <= mul_q8;
          2'd1:    pre_q.g <= mul_q8;
          default: pre_q.b <= mul_q8;
        endcase
        ch_q <= ch_q + 1'b1;
      end
      p2a_pkg::HS_RANGE: begin
        maxc_q  <= maxc;
        dlt_q   <= mx - mn;
        sum_q   <= 9'(mx) + 9'(mn);
        neg_q   <= (pa < pb);
        adiff_q <= (pa < pb) ? (pb - pa) : (pa - pb);
      end
      p2a_pkg::HS_LIGHT: begin
        hsl_q.l <= 7'(lit_q8 >> 1);
        sden_q  <= sum_q[8] ? 8'(p2a_pkg::SUM_FULL - sum_q) : sum_q[7:0];
        if (dlt_q == '0) begin
          hsl_q.h <= '0;
          hsl_q.s <= '0;
        end
      end
      p2a_pkg::HS_HUE_WAIT: if (div_done) hsl_q.h <= hue_val;
      p2a_pkg::HS_SAT_WAIT: if (div_done) hsl_q.s <= div_quot[6:0];
      default: ;
    endcase
  end

  assign pre_o = pre_q;
  assign hsl_o = hsl_q;

endmodule

// ===== src/p2a_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2a_search
// hsl palette memory and a pipelined walk for the smallest squared distance
// ----------------------------------------------------------------------------
module p2a_search #(
  parameter  int PALETTE_ENTRIES = 256,
  localparam int IW              = $clog2(PALETTE_ENTRIES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  p2a_pkg::hsl_t wr_hsl_i,
  input  logic          start_i,
  input  logic          space_i,
  input  p2a_pkg::pix_t pix_rgb_i,
  input  p2a_pkg::hsl_t pix_hsl_i,
  output logic          done_o,
  output logic [7:0]    best_o
);

  localparam logic [IW-1:0] LAST = IW'(PALETTE_ENTRIES - 1);

  p2a_pkg::hsl_t mem [PALETTE_ENTRIES];

  logic          issue_q;
  logic [IW-1:0] ic_q;
  logic          v1_q, v2_q, done_q;
  logic [IW-1:0] idx1_q, idx2_q;
  p2a_pkg::hsl_t ent_hsl_q;
  p2a_pkg::pix_t ent_rgb_q;

  logic [p2a_pkg::SQ_W-1:0]   sq0_q, sq1_q, sq2_q;
  logic [p2a_pkg::DIST_W-1:0] dist_sum, best_d_q;
  logic [7:0]                 best_q;

  // memory, written during the fill pass, read once per issued entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_hsl_i;
    end
    ent_hsl_q <= mem[ic_q];
    ent_rgb_q <= p2a_pkg::pix_t'(p2a_pkg::PAL_RGB[8'(ic_q)]);
  end

  // component differences in the chosen space
  logic signed [9:0]  a0, a1, a2;
  logic signed [19:0] p0, p1, p2;

  always_comb begin
    if (space_i) begin
      a0 = $signed({1'b0, pix_hsl_i.h}) - $signed({1'b0, ent_hsl_q.h});
      a1 = $signed({3'b0, pix_hsl_i.s}) - $signed({3'b0, ent_hsl_q.s});
      a2 = $signed({3'b0, pix_hsl_i.l}) - $signed({3'b0, ent_hsl_q.l});
    end else begin
      a0 = $signed({2'b0, pix_rgb_i.r}) - $signed({2'b0, ent_rgb_q.r});
      a1 = $signed({2'b0, pix_rgb_i.g}) - $signed({2'b0, ent_rgb_q.g});
      a2 = $signed({2'b0, pix_rgb_i.b}) - $signed({2'b0, ent_rgb_q.b});
    end
    p0       = a0 * a0;
    p1       = a1 * a1;
    p2       = a2 * a2;
    dist_sum = p2a_pkg::DIST_W'(sq0_q) + p2a_pkg::DIST_W'(sq1_q)
             + p2a_pkg::DIST_W'(sq2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (start_i && !issue_q) begin
        issue_q <= 1'b1;
      end else if (issue_q && (ic_q == LAST)) begin
        issue_q <= 1'b0;
      end
      v1_q   <= issue_q;
      v2_q   <= v1_q;
      done_q <= v2_q && (idx2_q == LAST);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !issue_q) begin
      ic_q <= '0;
    end else if (issue_q) begin
      ic_q <= ic_q + 1'b1;
    end
    idx1_q <= ic_q;
    idx2_q <= idx1_q;
    sq0_q  <= p0[p2a_pkg::SQ_W-1:0];
    sq1_q  <= p1[p2a_pkg::SQ_W-1:0];
    sq2_q  <= p2[p2a_pkg::SQ_W-1:0];
    // first entry always wins, later ones only when strictly closer
    if (v2_q && ((idx2_q == '0) || (dist_sum < best_d_q))) begin
      best_d_q <= dist_sum;
      best_q   <= 8'(idx2_q);
    end
  end

  assign done_o = done_q;
  assign best_o = best_q;

endmodule

// ===== src/pixel_to_ansi256_nearest_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_ansi256_nearest_core
// nearest xterm-256 palette entry for one premultiplied rgba pixel
// ----------------------------------------------------------------------------
// One pixel beat in, one result beat out: the color is premultiplied by
// alpha, turned into integer hsl (hue in degrees, saturation and lightness in
// percent) and then compared against every palette entry, in rgb or hsl as
// match_space selects, keeping the lowest index on equal distances. The block
// takes one pixel at a time: conversion (the accept step, a premultiply step
// per channel, range and lightness steps, two passes of the shared radix-2
// divider for hue and saturation, launch included, and a handoff step; grey
// pixels skip the divider) is followed by the palette walk, which reads one
// entry of the hsl memory per cycle. After reset the hsl palette is built by
// running each rgb entry through the same converter, during which no pixel
// is taken; register writes are taken at any time. A finished result sits in
// an output register, so the next pixel can be taken while it waits.
// ----------------------------------------------------------------------------
`include "pixel_to_ansi256_nearest_core_defines.svh"

module pixel_to_ansi256_nearest_core #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  p2a_pix_if.sink                    pix_i,
  p2a_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [p2a_pkg::APB_AW-1:0] paddr,
  input  logic [p2a_pkg::APB_DW-1:0] pwdata,
  output logic [p2a_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int            IW   = $clog2(PALETTE_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(PALETTE_ENTRIES - 1);

  // --------------------------------------------------------------------------
  // register port: word address in paddr[2], one register at word 0
  // --------------------------------------------------------------------------
  logic match_space_q;
  logic reg_idx;
  logic reg_wr;

  assign reg_idx = paddr[p2a_pkg::APB_AW-1];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_space_q <= p2a_pkg::MATCH_SPACE_RST;
    end else if (reg_wr && (reg_idx == p2a_pkg::REG_MATCH_SPACE)) begin
      match_space_q <= pwdata[0];
    end
  end

  always_comb begin
    // reads of unused words return zero
    if (reg_idx == p2a_pkg::REG_MATCH_SPACE) begin
      prdata = {{(p2a_pkg::APB_DW - 1){1'b0}}, match_space_q};
    end else begin
      prdata = '0;
    end
  end

  // --------------------------------------------------------------------------
  // converter and palette walk
  // --------------------------------------------------------------------------
  p2a_pkg::top_state_e state_q, state_d;
  logic [IW-1:0]       fill_idx_q;

  logic          hsl_start;
  p2a_pkg::pix_t hsl_pix;
  logic [7:0]    hsl_alpha;
  logic          hsl_done;
  p2a_pkg::pix_t hsl_pre;
  p2a_pkg::hsl_t hsl_res;

  logic          srch_start;
  logic          srch_done;
  logic [7:0]    srch_best;
  logic          fill_wr;

  p2a_hsl u_hsl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hsl_start),
    .pix_i   (hsl_pix),
    .alpha_i (hsl_alpha),
    .done_o  (hsl_done),
    .pre_o   (hsl_pre),
    .hsl_o   (hsl_res)
  );

  p2a_search #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fill_wr),
    .wr_addr_i (fill_idx_q),
    .wr_hsl_i  (hsl_res),
    .start_i   (srch_start),
    .space_i   (match_space_q),
    .pix_rgb_i (hsl_pre),
    .pix_hsl_i (hsl_res),
    .done_o    (srch_done),
    .best_o    (srch_best)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic       out_valid_q;
  logic       out_free;
  logic       out_load;
  logic [7:0] out_idx_q;
  logic [8:0] out_hue_q;
  logic [6:0] out_sat_q;
  logic [6:0] out_lit_q;

  // slot is free when empty or when its beat leaves this cycle
  assign out_free = !out_valid_q || res_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      p2a_pkg::ST_FILL_GO:   state_d = p2a_pkg::ST_FILL_WAIT;
      p2a_pkg::ST_FILL_WAIT: begin
        if (hsl_done) begin
          state_d = (fill_idx_q == LAST) ? p2a_pkg::ST_IDLE : p2a_pkg::ST_FILL_GO;
        end
      end
      p2a_pkg::ST_IDLE:      if (pix_i.valid) state_d = p2a_pkg::ST_CONV;
      p2a_pkg::ST_CONV:      if (hsl_done) state_d = p2a_pkg::ST_SEARCH;
      p2a_pkg::ST_SEARCH: begin
        if (srch_done) begin
          state_d = out_free ? p2a_pkg::ST_IDLE : p2a_pkg::ST_HOLD;
        end
      end
      p2a_pkg::ST_HOLD:      if (out_free) state_d = p2a_pkg::ST_IDLE;
      default:               state_d = p2a_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pix_i.ready = 1'b0;
    hsl_start   = 1'b0;
    srch_start  = 1'b0;
    fill_wr     = 1'b0;
    out_load    = 1'b0;
    // palette rgb entries go through at full opacity, which leaves them as is
    hsl_pix     = p2a_pkg::pix_t'(p2a_pkg::PAL_RGB[8'(fill_idx_q)]);
    hsl_alpha   = p2a_pkg::ALPHA_OPAQUE;
    unique case (state_q)
      p2a_pkg::ST_FILL_GO:   hsl_start = 1'b1;
      p2a_pkg::ST_FILL_WAIT: fill_wr = hsl_done;
      p2a_pkg::ST_IDLE: begin
        pix_i.ready = 1'b1;
        hsl_start   = pix_i.valid;
        hsl_pix     = '{r: pix_i.red, g: pix_i.green, b: pix_i.blue};
        hsl_alpha   = pix_i.alpha;
      end
      p2a_pkg::ST_CONV:      srch_start = hsl_done;
      p2a_pkg::ST_SEARCH:    out_load = srch_done && out_free;
      p2a_pkg::ST_HOLD:      out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= p2a_pkg::ST_FILL_GO;
      fill_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fill_wr && (fill_idx_q != LAST)) begin
        fill_idx_q <= fill_idx_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, held by the converter and search until the next pixel
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q <= srch_best;
      out_hue_q <= hsl_res.h;
      out_sat_q <= hsl_res.s;
      out_lit_q <= hsl_res.l;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.palette_index = out_idx_q;
  assign res_o.hue           = out_hue_q;
  assign res_o.saturation    = out_sat_q;
  assign res_o.lightness     = out_lit_q;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `P2A_ASSERT_IMPL(a_hsl_done_phase, clk_i, rst_ni, hsl_done, (state_q == p2a_pkg::ST_CONV) || (state_q == p2a_pkg::ST_FILL_WAIT), "converter finished outside a conversion")
  `P2A_ASSERT_IMPL(a_srch_done_phase, clk_i, rst_ni, srch_done, state_q == p2a_pkg::ST_SEARCH, "palette walk finished outside a search")
  `P2A_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, pix_i.valid && pix_i.ready, state_q == p2a_pkg::ST_CONV, "accepted pixel beat did not start a conversion")
  `P2A_ASSERT_IMPL(a_res_range, clk_i, rst_ni, res_o.valid, (res_o.hue < 9'd360) && (res_o.saturation <= 7'd100) && (res_o.lightness <= 7'd100), "result beat out of range")

endmodule
